FILE: src/fps_pkg.sv
package fps_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int MAX_SAMPLES = 64;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int COORD_W     = 16;
    localparam int DIST_W      = 34;
    localparam int SCNT_W      = 7;
    localparam int CFG_W       = 34;
    localparam int CFG_ADDR_W  = 1;
    localparam int OUT_IDX_W   = 10;

    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_COUNT  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_MAGNITUDE = 1'b1;

    localparam logic [SCNT_W-1:0] SAMPLE_COUNT_RESET  = 7'd16;
    localparam logic [DIST_W-1:0] MIN_MAGNITUDE_RESET = 34'd16777;

    // Front to back: one queued cloud-load or sampling command
    typedef struct packed {
        logic                     start;    // 1: run sampling, 0: store point
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_cmd;

    // Squared difference of 16-bit signed operands, via a 17-bit signed difference
    function automatic logic [DIST_W-1:0] sq_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic signed [2*COORD_W+1:0] e;
        logic        [2*COORD_W+1:0] p;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        e = d;
        p = $unsigned(e * e);
        return DIST_W'(p);
    endfunction

endpackage

FILE: src/fps_front.sv
module fps_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [fps_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [fps_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [fps_pkg::COORD_W-1:0] i_point_z,
    input  logic                              i_last_point,
    output logic                              o_cmd_valid,
    input  logic                              i_cmd_ready,
    output fps_pkg::t_cmd                     o_cmd
);
    // Two-entry queue; a last item is split into a point then a start.
    fps_pkg::t_cmd r_q [2];
    logic [1:0]    r_cnt;
    logic          r_rd;
    logic          r_pend_start;

    logic          push, pop;
    fps_pkg::t_cmd push_cmd;

    assign o_ready     = !r_pend_start && (r_cnt < 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        push     = 1'b0;
        push_cmd = '{start: 1'b1, x: '0, y: '0, z: '0};
        if (r_pend_start) begin
            push = (r_cnt < 2'd2) || pop;
        end else if (i_valid && o_ready) begin
            push     = 1'b1;
            push_cmd = '{start: 1'b0, x: i_point_x, y: i_point_y, z: i_point_z};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_rd         <= 1'b0;
            r_pend_start <= 1'b0;
        end else begin
            if (push) r_q[r_rd ^ (r_cnt == 2'd1) ^ (pop && r_cnt != 2'd0) ^ pop] <= push_cmd;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
            if (r_pend_start && push)             r_pend_start <= 1'b0;
            else if (!r_pend_start && i_valid && o_ready && i_last_point) r_pend_start <= 1'b1;
        end
    end

endmodule

FILE: src/fps_back.sv
module fps_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [fps_pkg::SCNT_W-1:0]          i_sample_count,
    input  logic [fps_pkg::DIST_W-1:0]          i_min_magnitude,
    input  logic                                i_cmd_valid,
    output logic                                o_cmd_ready,
    input  fps_pkg::t_cmd                       i_cmd,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [fps_pkg::OUT_IDX_W-1:0]       o_sample_index,
    output logic                                o_last_sample
);
    localparam int IW = fps_pkg::IDX_W;
    localparam int CW = fps_pkg::CNT_W;
    localparam int DW = fps_pkg::DIST_W;
    localparam int PW = 3 * fps_pkg::COORD_W;

    typedef enum logic [2:0] {S_LOAD, S_INIT, S_EMIT, S_RDREF, S_SCAN, S_DONE} t_state;

    logic [PW-1:0] r_pts  [fps_pkg::MAX_POINTS];
    logic [DW-1:0] r_near [fps_pkg::MAX_POINTS];

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [fps_pkg::SCNT_W-1:0] r_total, r_made;
    logic [IW-1:0]       r_pick, r_best_idx;
    logic [DW-1:0]       r_best;
    logic                r_found;
    logic [CW-1:0]       r_k;        // read address counter
    logic signed [fps_pkg::COORD_W-1:0] r_x1, r_y1, r_z1;
    // pipeline: stage1 read data, stage2 distance
    logic [PW-1:0]       r_p1;
    logic [DW-1:0]       r_n1;
    logic                r_v1;
    logic [IW-1:0]       r_i1;
    logic [DW-1:0]       r_d2, r_n2, r_m2;
    logic                r_v2;
    logic [IW-1:0]       r_i2;
    logic                r_ov;
    logic [IW-1:0]       r_oidx;
    logic                r_olast;

    logic signed [fps_pkg::COORD_W-1:0] x2, y2, z2;
    logic [DW-1:0] dnew, dmin;
    logic          qual;
    logic          emit;

    assign o_cmd_ready    = (r_state == S_LOAD);
    assign o_valid        = r_ov;
    assign o_sample_index = fps_pkg::OUT_IDX_W'(r_oidx);
    assign o_last_sample  = r_olast;

    assign x2 = r_p1[15:0];
    assign y2 = r_p1[31:16];
    assign z2 = r_p1[47:32];
    assign dmin = (r_d2 < r_n2) ? r_d2 : r_n2;
    assign qual = r_m2 > i_min_magnitude;
    assign emit = (r_state == S_EMIT) && (r_made != r_total) && (!r_ov || i_ready);

    // memories
    always_ff @(posedge i_clk) begin
        if (o_cmd_ready && i_cmd_valid && !i_cmd.start
            && r_count < CW'(fps_pkg::MAX_POINTS))
            r_pts[r_count[IW-1:0]] <= {i_cmd.z, i_cmd.y, i_cmd.x};
        if (r_state == S_INIT) r_near[r_k[IW-1:0]] <= '1;
        if (r_v2 && qual && r_d2 < r_n2) r_near[r_i2] <= r_d2;
        r_p1 <= r_pts[r_k[IW-1:0]];
        r_n1 <= r_near[r_k[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_k     <= '0;
        end else begin
            if (emit)                r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
            r_v2 <= r_v1;
            r_i2 <= r_i1;
            r_d2 <= fps_pkg::sq_diff(x2, r_x1) + fps_pkg::sq_diff(y2, r_y1)
                  + fps_pkg::sq_diff(z2, r_z1);
            r_n2 <= r_n1;
            r_m2 <= fps_pkg::sq_diff(x2, '0) + fps_pkg::sq_diff(y2, '0)
                  + fps_pkg::sq_diff(z2, '0);
            r_v1 <= (r_state == S_SCAN) && (r_k < r_count);
            case (r_state)
                S_LOAD: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.start) begin
                            r_total <= (i_sample_count > fps_pkg::SCNT_W'(fps_pkg::MAX_SAMPLES))
                                     ? fps_pkg::SCNT_W'(fps_pkg::MAX_SAMPLES) : i_sample_count;
                            r_made  <= '0;
                            r_pick  <= '0;
                            r_k     <= '0;
                            r_state <= S_INIT;
                        end else if (r_count < CW'(fps_pkg::MAX_POINTS)) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_INIT: begin
                    if (r_k + 1'b1 >= r_count) r_state <= S_EMIT;
                    r_k <= r_k + 1'b1;
                end
                S_EMIT: begin
                    if (r_made == r_total) begin
                        r_state <= S_DONE;
                    end else if (!r_ov || i_ready) begin
                        r_oidx  <= r_pick;
                        r_olast <= (r_made + 1'b1 == r_total);
                        r_made  <= r_made + 1'b1;
                        r_k     <= CW'(r_pick);
                        if (r_made + 1'b1 == r_total) r_state <= S_DONE;
                        else                          r_state <= S_RDREF;
                    end
                end
                S_RDREF: begin
                    // Reference coordinates are read straight from the point memory at r_pick
                    r_k     <= '0;
                    r_state <= S_SCAN;
                    r_found <= 1'b0;
                    r_best  <= '0;
                    r_best_idx <= '0;
                    r_x1 <= r_pts[r_pick][15:0];
                    r_y1 <= r_pts[r_pick][31:16];
                    r_z1 <= r_pts[r_pick][47:32];
                end
                S_SCAN: begin
                    if (r_k < r_count) begin
                        r_i1 <= r_k[IW-1:0];
                        r_k  <= r_k + 1'b1;
                    end
                    if (r_v2 && qual && (!r_found || dmin > r_best)) begin
                        r_found    <= 1'b1;
                        r_best     <= dmin;
                        r_best_idx <= r_i2;
                    end
                    if (r_k >= r_count && !r_v1 && !r_v2) begin
                        r_pick  <= r_best_idx;
                        r_state <= S_EMIT;
                    end
                end
                S_DONE: begin
                    r_count <= '0;
                    r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule

FILE: src/furthest_point_sampler.sv
// Furthest point sampler.
// Input channel (i_valid/o_ready): one point per transfer, Q3.12 x/y/z;
// i_last_point ends a cloud and starts sampling. Points past 1024 are dropped.
// Output channel (o_valid/i_ready): sample_count indices (max 64), the final
// one flagged by o_last_sample; first index is always point 0.
// Config: i_cfg_we/i_cfg_addr/i_cfg_data, index 0 sample_count, 1 min_magnitude;
// write only while idle.
// Sampling first resets the distance of every stored point, then makes one
// scan of the point memory per pick.
// A short command queue parts the front from the back, so input is taken
// while the back is busy until the queue fills.
// Reset (synchronous, active low) empties the store, restores registers
// to 16 and 16777. A stalled receiver holds the index register, and the
// next index waits for it while the scan goes on.
module furthest_point_sampler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [fps_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [fps_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [fps_pkg::COORD_W-1:0]   i_point_x,
    input  logic signed [fps_pkg::COORD_W-1:0]   i_point_y,
    input  logic signed [fps_pkg::COORD_W-1:0]   i_point_z,
    input  logic                                 i_last_point,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [fps_pkg::OUT_IDX_W-1:0]        o_sample_index,
    output logic                                 o_last_sample
);
    logic [fps_pkg::SCNT_W-1:0] r_sample_count;
    logic [fps_pkg::DIST_W-1:0] r_min_magnitude;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count  <= fps_pkg::SAMPLE_COUNT_RESET;
            r_min_magnitude <= fps_pkg::MIN_MAGNITUDE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                fps_pkg::REG_SAMPLE_COUNT:  r_sample_count  <= i_cfg_data[fps_pkg::SCNT_W-1:0];
                fps_pkg::REG_MIN_MAGNITUDE: r_min_magnitude <= i_cfg_data[fps_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    logic          cmd_valid, cmd_ready;
    fps_pkg::t_cmd cmd;

    fps_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_point_x, .i_point_y, .i_point_z, .i_last_point,
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    fps_back u_back (
        .i_clk, .i_rst_n,
        .i_sample_count(r_sample_count), .i_min_magnitude(r_min_magnitude),
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_valid, .i_ready, .o_sample_index, .o_last_sample
    );

endmodule

FILE: src/fps_checker.sv
module fps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [9:0] o_sample_index,
    input logic       o_last_sample
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample_index)) else $error("out hold");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_last_sample)) else $error("last hold");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
endmodule

bind furthest_point_sampler fps_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_sample_index, .o_last_sample
);
